### rtl/core/gstcr_pkg.sv
// Package for the gradient stop table colour ramp.
// Holds sizes, the mode, status and state codes, and the payload structs.
package gstcr_pkg;

  localparam int MAX_STOPS = 16;
  localparam int IDX_W     = $clog2(MAX_STOPS);
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_SAMPLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_USED     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] position;
    logic [31:0] stop_rgba;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_DIV,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic rd_lo;      // read entries idx-1 and idx into holding regs
    logic sh_idx;     // shift pointer to the hit index (remove)
    logic shift_up;
    logic shift_dn;
    logic wr_new;     // write position and colour at idx
    logic wr_color;   // write colour only at idx
    logic cnt_inc;
    logic cnt_dec;
    logic div_start;
    logic div_step;
    logic done;
    logic [1:0] status;
    logic [1:0] res_sel;  // 0 zero, 1 gray, 2 stop colour, 3 blend
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic hit;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_end;
    logic up_end;     // upward shift has reached the insert index
    logic dn_end;     // downward shift has reached the last stop
    logic div_end;
  } sts_t;

  localparam logic [1:0] RS_ZERO  = 2'd0;
  localparam logic [1:0] RS_GRAY  = 2'd1;
  localparam logic [1:0] RS_STOP  = 2'd2;
  localparam logic [1:0] RS_BLEND = 2'd3;

endpackage

### rtl/core/gstcr_ctrl.sv
// Controller state machine of the colour ramp.
// Depends on gstcr_pkg; drives the datapath through ctl_t, sees sts_t.
module gstcr_ctrl import gstcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic [1:0] mode,
  input  sts_t     sts,
  output ctl_t     ctl,
  output logic     busy
);

  state_t state_r, state_nxt;
  logic [1:0] mode_r;

  // state and latched mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_IDLE && start) begin
      mode_r <= mode;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_READ;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_READ: begin
        ctl.rd_lo = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        ctl.done = 1'b1;
        ctl.status = ST_OK;
        ctl.res_sel = RS_ZERO;
        case (mode_r)
          MODE_ADD: begin
            if (sts.hit) begin
              ctl.status = ST_USED;
            end else if (sts.full) begin
              ctl.status = ST_FULL;
            end else begin
              ctl.done = 1'b0;
              state_nxt = S_SHIFT_UP;
            end
          end
          MODE_REMOVE: begin
            if (!sts.hit) begin
              ctl.status = ST_NOTFOUND;
            end else begin
              ctl.done = 1'b0;
              ctl.sh_idx = 1'b1;
              state_nxt = S_SHIFT_DN;
            end
          end
          MODE_CHANGE: begin
            if (!sts.hit) begin
              ctl.status = ST_NOTFOUND;
            end else begin
              ctl.wr_color = 1'b1;
            end
          end
          default: begin
            if (sts.empty) begin
              ctl.res_sel = RS_GRAY;
            end else if (sts.hit || sts.idx_zero || sts.idx_end) begin
              ctl.res_sel = RS_STOP;
            end else begin
              ctl.done = 1'b0;
              ctl.div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_SHIFT_UP: begin
        if (sts.up_end) begin
          state_nxt = S_WRITE;
        end else begin
          ctl.shift_up = 1'b1;
        end
      end
      S_WRITE: begin
        ctl.wr_new = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.done = 1'b1;
        ctl.status = ST_OK;
        ctl.res_sel = RS_ZERO;
        state_nxt = S_IDLE;
      end
      S_SHIFT_DN: begin
        if (sts.dn_end) begin
          ctl.cnt_dec = 1'b1;
          ctl.done = 1'b1;
          ctl.status = ST_OK;
          ctl.res_sel = RS_ZERO;
          state_nxt = S_IDLE;
        end else begin
          ctl.shift_dn = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_end) begin
          state_nxt = S_DONE;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      S_DONE: begin
        ctl.done = 1'b1;
        ctl.status = ST_OK;
        ctl.res_sel = RS_BLEND;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // an item is never accepted while busy
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !busy) else $error("load while busy");
  // completion returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> !busy) else $error("done without idle");
  // shifts only for table edits
  a_shift_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift_up || ctl.shift_dn) |-> (mode_r == MODE_ADD || mode_r == MODE_REMOVE))
    else $error("shift outside edit");

endmodule

### rtl/core/gstcr_dp.sv
// Datapath of the colour ramp: stop table, scan pointer, serial divider.
// Depends on gstcr_pkg; commanded by gstcr_ctrl.
module gstcr_dp import gstcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_word_t out_word,
  output logic      out_strobe
);

  localparam int NUM_W = 25;  // 255*65535 + 32767 fits in 25 bits

  logic [15:0] pos_tab [MAX_STOPS];
  logic [31:0] col_tab [MAX_STOPS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;   // scan index, then insert/remove index
  logic [CNT_W-1:0] sh_r;    // shift pointer
  logic [15:0] pos_r;
  logic [31:0] rgba_r;
  logic [15:0] p0_r, p1_r;
  logic [31:0] c0_r, c1_r;
  logic [31:0] chit_r;
  logic [15:0] d_r;
  logic [NUM_W-1:0] num_r [4];
  logic [NUM_W-1:0] rem_r [4];
  logic [7:0] q_r [4];
  logic [4:0] dcnt_r;
  logic [7:0] gray;
  logic [8:0] gq;
  logic [17:0] gsum;

  logic [IDX_W-1:0] ia, ib;
  assign ia = idx_r[IDX_W-1:0];
  assign ib = idx_r[IDX_W-1:0] - 1'b1;

  // status for the controller
  always_comb begin
    sts.scan_end = (idx_r == cnt_r) || (pos_tab[ia] >= pos_r);
    sts.hit = (idx_r != cnt_r) && (pos_tab[ia] == pos_r);
    sts.full = (cnt_r == CNT_W'(MAX_STOPS));
    sts.empty = (cnt_r == '0);
    sts.idx_zero = (idx_r == '0);
    sts.idx_end = (idx_r == cnt_r);
    sts.up_end = (sh_r == idx_r);
    sts.dn_end = (sh_r + 1'b1 >= cnt_r);
    sts.div_end = (dcnt_r == 5'd0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctl.done;
      if (ctl.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (ctl.cnt_dec) cnt_r <= cnt_r - 1'b1;
    end
  end

  // scan, table shifts and writes
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r <= in_word.position;
      rgba_r <= in_word.stop_rgba;
      idx_r <= '0;
    end
    if (ctl.scan_step) idx_r <= idx_r + 1'b1;
    if (ctl.rd_lo) begin
      p0_r <= pos_tab[ib];
      c0_r <= col_tab[ib];
      p1_r <= pos_tab[ia];
      c1_r <= col_tab[ia];
      chit_r <= (idx_r == '0) ? col_tab[0] :
                (idx_r == cnt_r) ? col_tab[ib] : col_tab[ia];
      sh_r <= cnt_r;
    end
    // remove starts its shift at the hit index
    if (ctl.sh_idx) sh_r <= idx_r;
    if (ctl.shift_up) begin
      pos_tab[sh_r[IDX_W-1:0]] <= pos_tab[sh_r[IDX_W-1:0] - 1'b1];
      col_tab[sh_r[IDX_W-1:0]] <= col_tab[sh_r[IDX_W-1:0] - 1'b1];
      sh_r <= sh_r - 1'b1;
    end
    if (ctl.shift_dn) begin
      pos_tab[sh_r[IDX_W-1:0]] <= pos_tab[sh_r[IDX_W-1:0] + 1'b1];
      col_tab[sh_r[IDX_W-1:0]] <= col_tab[sh_r[IDX_W-1:0] + 1'b1];
      sh_r <= sh_r + 1'b1;
    end
    if (ctl.wr_new) begin
      pos_tab[ia] <= pos_r;
      col_tab[ia] <= rgba_r;
    end
    if (ctl.wr_color) col_tab[ia] <= rgba_r;
  end

  // divider: restoring, one quotient bit per cycle, four channels in parallel
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      d_r <= p1_r - p0_r;
      for (int k = 0; k < 4; k++) begin
        num_r[k] <= NUM_W'(c0_r[8*k +: 8]) * NUM_W'(p1_r - pos_r) +
                    NUM_W'(c1_r[8*k +: 8]) * NUM_W'(pos_r - p0_r) +
                    NUM_W'((p1_r - p0_r) >> 1);
        rem_r[k] <= '0;
        q_r[k] <= '0;
      end
      dcnt_r <= 5'(NUM_W);
    end else if (ctl.div_step) begin
      for (int k = 0; k < 4; k++) begin
        logic [NUM_W-1:0] tr;
        tr = {rem_r[k][NUM_W-2:0], num_r[k][NUM_W-1]};
        num_r[k] <= {num_r[k][NUM_W-2:0], 1'b0};
        if (tr >= NUM_W'(d_r)) begin
          rem_r[k] <= tr - NUM_W'(d_r);
          q_r[k] <= {q_r[k][6:0], 1'b1};
        end else begin
          rem_r[k] <= tr;
          q_r[k] <= {q_r[k][6:0], 1'b0};
        end
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // gray for the empty table: (p+128)/257, estimate by >>8 then correct by one
  always_comb begin
    gsum = 18'(pos_r) + 18'd128;
    gq = 9'(gsum >> 8);
    if (18'(gq) * 18'd257 > gsum) gq = gq - 1'b1;
    gray = gq[7:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_word.status <= ctl.status;
      case (ctl.res_sel)
        RS_GRAY:  {out_word.red, out_word.green, out_word.blue, out_word.alpha}
                    <= {gray, gray, gray, 8'hFF};
        RS_STOP:  {out_word.red, out_word.green, out_word.blue, out_word.alpha}
                    <= chit_r;
        RS_BLEND: {out_word.red, out_word.green, out_word.blue, out_word.alpha}
                    <= {q_r[3], q_r[2], q_r[1], q_r[0]};
        default:  {out_word.red, out_word.green, out_word.blue, out_word.alpha}
                    <= '0;
      endcase
    end
  end

  // count never exceeds the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_STOPS)) else $error("count overflow");
  // no add on a full table
  a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_inc |-> !sts.full) else $error("add to full table");
  // a strobe follows each completion
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> out_strobe) else $error("missing strobe");

endmodule

### rtl/core/gradient_stop_table_color_ramp.sv
// Gradient stop table colour ramp, top level. Uses gstcr_pkg, gstcr_ctrl, gstcr_dp.
// Operation: the scan steps over the L stops below the position, 1 a cycle; then
// come a read and a decide state. Add then shifts the later stops up and writes,
// remove shifts them down, an interpolated sample runs a 25-bit serial divide.
// Throughput: one word at a time; the strobe rises in the same cycle that busy drops.
// Reset: synchronous rst_n clears count and controller; table contents undefined.
module gradient_stop_table_color_ramp import gstcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_strobe
);

  ctl_t ctl;
  sts_t sts;

  gstcr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_word.mode),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  gstcr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .ctl        (ctl),
    .sts        (sts),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule
